// ===== design/shadow_quad_from_box_unit_macros.svh =====
// Assertion macros shared by the shadow quad design files.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SHADOW_QUAD_FROM_BOX_UNIT_MACROS_SVH
`define SHADOW_QUAD_FROM_BOX_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SQFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shadow quad assertion failed");
// Next-cycle implication, disabled during reset.
`define SQFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shadow quad assertion failed");
`else
`define SQFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SQFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/sqfb_pkg.sv =====
// Package for the shadow quad unit: payload types, constants, sequencer states
// and the CORDIC arctangent table. No dependencies.
`default_nettype none

package sqfb_pkg;

    // Iteration and stepping limits.
    localparam int MAX_ANGLE_STEPS   = 360;
    localparam int CORDIC_ITERATIONS = 18;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
    localparam int STEP_W            = $clog2(MAX_ANGLE_STEPS + 1);
    localparam int ITER_W            = 5;

    // Internal coordinates are 1/512 pixel, angles are 1/65536 degree.
    typedef logic signed [31:0] word_t;

    localparam word_t DEG_ONE     = 32'sd65536;
    localparam word_t DEG_QUARTER = 32'sd5898240;
    localparam word_t DEG_HALF    = 32'sd11796480;
    localparam word_t DEG_FULL    = 32'sd23592960;
    localparam logic [15:0] INV_GAIN = 16'd39797;

    localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] COORD_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [23:0] light_x;
        logic signed [23:0] light_y;
        logic        [23:0] light_radius;
        logic signed [23:0] box_left;
        logic signed [23:0] box_top;
        logic        [23:0] box_width;
        logic        [23:0] box_height;
    } job_t;

    typedef struct packed {
        logic signed [23:0] near_right_x;
        logic signed [23:0] near_right_y;
        logic signed [23:0] far_right_x;
        logic signed [23:0] far_right_y;
        logic signed [23:0] far_left_x;
        logic signed [23:0] far_left_y;
        logic signed [23:0] near_left_x;
        logic signed [23:0] near_left_y;
        logic               gave_up;
    } quad_t;

    typedef enum logic {
        CM_VECTOR,
        CM_ROTATE
    } cordic_mode_t;

    typedef struct packed {
        logic         start;
        cordic_mode_t mode;
    } cordic_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_sts_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VEC,
        S_VEC_WAIT,
        S_VEC_GAIN,
        S_WALK,
        S_EMIT,
        S_PT_NORM,
        S_PT_FOLD,
        S_PT_ROT,
        S_PT_WAIT,
        S_PT_DONE,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_DOWN,
        PH_NR,
        PH_FR,
        PH_UP,
        PH_FL,
        PH_NL
    } phase_t;

    // atan(2^-i) in 1/65536 degree.
    function automatic word_t atan_deg(input logic [ITER_W-1:0] idx);
        word_t v;
        case (idx)
            5'd0:    v = 32'sd2949120;
            5'd1:    v = 32'sd1740967;
            5'd2:    v = 32'sd919879;
            5'd3:    v = 32'sd466945;
            5'd4:    v = 32'sd234379;
            5'd5:    v = 32'sd117304;
            5'd6:    v = 32'sd58666;
            5'd7:    v = 32'sd29335;
            5'd8:    v = 32'sd14668;
            5'd9:    v = 32'sd7334;
            5'd10:   v = 32'sd3667;
            5'd11:   v = 32'sd1833;
            5'd12:   v = 32'sd917;
            5'd13:   v = 32'sd458;
            5'd14:   v = 32'sd229;
            5'd15:   v = 32'sd115;
            5'd16:   v = 32'sd57;
            5'd17:   v = 32'sd29;
            5'd18:   v = 32'sd14;
            5'd19:   v = 32'sd7;
            5'd20:   v = 32'sd4;
            5'd21:   v = 32'sd2;
            5'd22:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Halve a 1/512 pixel coordinate (floor) and saturate to Q16.8.
    function automatic logic signed [23:0] to_q16_8(input word_t p);
        word_t h;
        logic signed [23:0] r;
        h = p >>> 1;
        if (h > 32'(COORD_MAX))
            r = COORD_MAX;
        else if (h < word_t'(COORD_MIN))
            r = COORD_MIN;
        else
            r = h[23:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/sqfb_job_if.sv =====
// Input channel of the shadow quad unit: valid/ready with one light and box.
// Depends on sqfb_pkg.
`default_nettype none

interface sqfb_job_if;
    logic          valid;
    logic          ready;
    sqfb_pkg::job_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/sqfb_quad_if.sv =====
// Output channel of the shadow quad unit: valid/ready with four corners.
// Depends on sqfb_pkg.
`default_nettype none

interface sqfb_quad_if;
    logic           valid;
    logic           ready;
    sqfb_pkg::quad_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/sqfb_cordic.sv =====
// Shared CORDIC engine, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on sqfb_pkg and shadow_quad_from_box_unit_macros.svh.
`default_nettype none
`include "shadow_quad_from_box_unit_macros.svh"

module sqfb_cordic (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sqfb_pkg::cordic_cmd_t cmd,
    input  wire sqfb_pkg::word_t      x_in,
    input  wire sqfb_pkg::word_t      y_in,
    input  wire sqfb_pkg::word_t      z_in,
    output      sqfb_pkg::cordic_sts_t sts,
    output      sqfb_pkg::word_t      x_out,
    output      sqfb_pkg::word_t      y_out,
    output      sqfb_pkg::word_t      z_out
);

    localparam logic [sqfb_pkg::ITER_W-1:0] LAST_ITER =
        sqfb_pkg::ITER_W'(sqfb_pkg::CORDIC_STEPS - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [sqfb_pkg::ITER_W-1:0]   iter_reg, iter_next;
    sqfb_pkg::cordic_mode_t        mode_reg, mode_next;
    sqfb_pkg::word_t               x_reg, x_next;
    sqfb_pkg::word_t               y_reg, y_next;
    sqfb_pkg::word_t               z_reg, z_next;

    sqfb_pkg::word_t               x_sh, y_sh, ang;
    logic                          pos_dir;

    // One micro-rotation: a positive direction turns the vector anticlockwise.
    always_comb
    begin
        x_sh = x_reg >>> iter_reg;
        y_sh = y_reg >>> iter_reg;
        ang  = sqfb_pkg::atan_deg(iter_reg);
        if (mode_reg == sqfb_pkg::CM_ROTATE)
            pos_dir = (z_reg >= 0);
        else
            pos_dir = !(y_reg > 0);

        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        mode_next = mode_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            mode_next = cmd.mode;
            x_next    = x_in;
            y_next    = y_in;
            z_next    = z_in;
        end
        else if (busy_reg)
        begin
            if (pos_dir)
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - ang;
            end
            else
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + ang;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == LAST_ITER)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
            mode_reg <= sqfb_pkg::CM_VECTOR;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
            mode_reg <= mode_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

    `SQFB_ASSERT_IMP(a_no_start_when_busy, clk, rst_n, busy_reg, !cmd.start)
    `SQFB_ASSERT_NXT(a_start_makes_busy, clk, rst_n, cmd.start, busy_reg && iter_reg == '0)
    `SQFB_ASSERT_IMP(a_done_after_last, clk, rst_n, done_reg, !busy_reg && $past(busy_reg))

endmodule

`default_nettype wire

// ===== design/shadow_quad_from_box_unit.sv =====
// Shadow quad unit top level: sequencer, gain multiplier and corner registers.
// Depends on sqfb_pkg, sqfb_job_if, sqfb_quad_if, sqfb_cordic and the macros header.
//
// Channel  Interface     Role    Transaction
// job      sqfb_job_if   sink    one light and one occluding box
// quad     sqfb_quad_if  source  four shadow corners and the gave_up flag
//
// Each circle point passes through angle reduction, gain multiply, the
// 18-iteration CORDIC engine and hand-off.
// The number of points per transaction grows with the down and up steps,
// and each walk is capped at 360 steps.
// job.ready is high only while idle; the result is held until quad.ready.
// Reset is asynchronous and clears only the control state.
`default_nettype none
`include "shadow_quad_from_box_unit_macros.svh"

module shadow_quad_from_box_unit (
    input wire logic clk,
    input wire logic rst_n,
    sqfb_job_if.sink    job,
    sqfb_quad_if.source quad
);

    localparam logic [sqfb_pkg::STEP_W-1:0] STEP_CAP =
        sqfb_pkg::STEP_W'(sqfb_pkg::MAX_ANGLE_STEPS);

    sqfb_pkg::state_t state_reg, state_next;
    sqfb_pkg::phase_t phase_reg, phase_next;
    logic [sqfb_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic gave_reg, gave_next;
    logic neg_reg, neg_next;

    sqfb_pkg::word_t lx_reg, lx_next, ly_reg, ly_next, rad_reg, rad_next;
    sqfb_pkg::word_t bl_reg, bl_next, bt_reg, bt_next, br_reg, br_next, bb_reg, bb_next;
    sqfb_pkg::word_t dx_reg, dx_next, dy_reg, dy_next;
    sqfb_pkg::word_t len_reg, len_next, ang_reg, ang_next;
    sqfb_pkg::word_t ptr_reg, ptr_next, za_reg, za_next, x0_reg, x0_next;
    sqfb_pkg::word_t px_reg, px_next, py_reg, py_next;
    sqfb_pkg::quad_t res_reg, res_next;

    sqfb_pkg::cordic_cmd_t cmd;
    sqfb_pkg::cordic_sts_t sts;
    sqfb_pkg::word_t c_xin, c_yin, c_zin, c_x, c_y, c_z;

    sqfb_pkg::word_t   mul_a;
    logic signed [48:0] prod;
    sqfb_pkg::word_t   gain_out, cx, cy, lx_in, bl_in;
    logic              in_box;

    sqfb_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .x_in  (c_xin),
        .y_in  (c_yin),
        .z_in  (c_zin),
        .sts   (sts),
        .x_out (c_x),
        .y_out (c_y),
        .z_out (c_z)
    );

    // Shared gain-correction multiplier, floor of the product over 2^16.
    always_comb
    begin
        mul_a    = (state_reg == sqfb_pkg::S_VEC_GAIN) ? c_x : ptr_reg;
        prod     = mul_a * $signed({1'b0, sqfb_pkg::INV_GAIN});
        gain_out = prod[47:16];
        cx       = neg_reg ? -c_x : c_x;
        cy       = neg_reg ? -c_y : c_y;
        in_box   = (px_reg >= bl_reg) && (px_reg < br_reg) &&
                   (py_reg >= bt_reg) && (py_reg < bb_reg);
        lx_in    = {{7{job.data.light_x[23]}}, job.data.light_x, 1'b0};
        bl_in    = {{7{job.data.box_left[23]}}, job.data.box_left, 1'b0};
    end

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        steps_next = steps_reg;
        gave_next  = gave_reg;
        neg_next   = neg_reg;
        lx_next    = lx_reg;
        ly_next    = ly_reg;
        rad_next   = rad_reg;
        bl_next    = bl_reg;
        bt_next    = bt_reg;
        br_next    = br_reg;
        bb_next    = bb_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        len_next   = len_reg;
        ang_next   = ang_reg;
        ptr_next   = ptr_reg;
        za_next    = za_reg;
        x0_next    = x0_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        res_next   = res_reg;
        cmd.start  = 1'b0;
        cmd.mode   = sqfb_pkg::CM_ROTATE;
        c_xin      = x0_reg;
        c_yin      = '0;
        c_zin      = za_reg;

        unique case (state_reg)
            sqfb_pkg::S_IDLE:
            begin
                if (job.valid)
                begin
                    lx_next  = lx_in;
                    ly_next  = {{7{job.data.light_y[23]}}, job.data.light_y, 1'b0};
                    rad_next = {7'd0, job.data.light_radius, 1'b0};
                    bl_next  = bl_in;
                    bt_next  = {{7{job.data.box_top[23]}}, job.data.box_top, 1'b0};
                    br_next  = bl_in + {7'd0, job.data.box_width, 1'b0};
                    bb_next  = {{7{job.data.box_top[23]}}, job.data.box_top, 1'b0}
                               + {7'd0, job.data.box_height, 1'b0};
                    dx_next  = bl_in + {8'd0, job.data.box_width} - lx_in;
                    dy_next  = {{7{job.data.box_top[23]}}, job.data.box_top, 1'b0}
                               + {8'd0, job.data.box_height}
                               - {{7{job.data.light_y[23]}}, job.data.light_y, 1'b0};
                    gave_next  = 1'b0;
                    state_next = sqfb_pkg::S_VEC;
                end
            end

            // Distance and bearing of the box centre; a zero vector gives both zero.
            sqfb_pkg::S_VEC:
            begin
                steps_next = '0;
                phase_next = sqfb_pkg::PH_DOWN;
                if (dx_reg == 0 && dy_reg == 0)
                begin
                    len_next   = '0;
                    ang_next   = '0;
                    state_next = sqfb_pkg::S_WALK;
                end
                else
                begin
                    cmd.start = 1'b1;
                    cmd.mode  = sqfb_pkg::CM_VECTOR;
                    if (dx_reg < 0)
                    begin
                        c_xin = -dx_reg;
                        c_yin = -dy_reg;
                        c_zin = (dy_reg >= 0) ? sqfb_pkg::DEG_HALF : -sqfb_pkg::DEG_HALF;
                    end
                    else
                    begin
                        c_xin = dx_reg;
                        c_yin = dy_reg;
                        c_zin = '0;
                    end
                    state_next = sqfb_pkg::S_VEC_WAIT;
                end
            end

            sqfb_pkg::S_VEC_WAIT:
            begin
                if (sts.done)
                    state_next = sqfb_pkg::S_VEC_GAIN;
            end

            sqfb_pkg::S_VEC_GAIN:
            begin
                len_next   = gain_out;
                ang_next   = c_z;
                state_next = sqfb_pkg::S_WALK;
            end

            // Test the point at the current angle unless the walk has hit its cap.
            sqfb_pkg::S_WALK:
            begin
                if (steps_reg == STEP_CAP)
                begin
                    gave_next = 1'b1;
                    if (phase_reg == sqfb_pkg::PH_DOWN)
                    begin
                        ang_next   = ang_reg + sqfb_pkg::DEG_ONE;
                        phase_next = sqfb_pkg::PH_NR;
                    end
                    else
                    begin
                        ang_next   = ang_reg - sqfb_pkg::DEG_ONE;
                        phase_next = sqfb_pkg::PH_FL;
                    end
                    state_next = sqfb_pkg::S_EMIT;
                end
                else
                begin
                    ptr_next   = len_reg;
                    za_next    = ang_reg;
                    state_next = sqfb_pkg::S_PT_NORM;
                end
            end

            // Pick radius and angle of the next corner.
            sqfb_pkg::S_EMIT:
            begin
                priority case (phase_reg)
                    sqfb_pkg::PH_FR:
                    begin
                        ptr_next = rad_reg;
                        za_next  = ang_reg - sqfb_pkg::DEG_ONE;
                    end
                    sqfb_pkg::PH_FL:
                    begin
                        ptr_next = rad_reg;
                        za_next  = ang_reg + sqfb_pkg::DEG_ONE;
                    end
                    default:
                    begin
                        ptr_next = len_reg;
                        za_next  = ang_reg;
                    end
                endcase
                state_next = sqfb_pkg::S_PT_NORM;
            end

            // Reduce the angle into the half-open range above minus a half turn.
            sqfb_pkg::S_PT_NORM:
            begin
                if (za_reg > sqfb_pkg::DEG_HALF)
                    za_next = za_reg - sqfb_pkg::DEG_FULL;
                else if (za_reg <= -sqfb_pkg::DEG_HALF)
                    za_next = za_reg + sqfb_pkg::DEG_FULL;
                else
                    state_next = sqfb_pkg::S_PT_FOLD;
            end

            // Fold into the right half-plane and scale the radius by the gain.
            sqfb_pkg::S_PT_FOLD:
            begin
                if (za_reg > sqfb_pkg::DEG_QUARTER)
                begin
                    za_next  = za_reg - sqfb_pkg::DEG_HALF;
                    neg_next = 1'b1;
                end
                else if (za_reg < -sqfb_pkg::DEG_QUARTER)
                begin
                    za_next  = za_reg + sqfb_pkg::DEG_HALF;
                    neg_next = 1'b1;
                end
                else
                    neg_next = 1'b0;
                x0_next    = gain_out;
                state_next = sqfb_pkg::S_PT_ROT;
            end

            sqfb_pkg::S_PT_ROT:
            begin
                cmd.start  = 1'b1;
                state_next = sqfb_pkg::S_PT_WAIT;
            end

            sqfb_pkg::S_PT_WAIT:
            begin
                if (sts.done)
                begin
                    px_next    = lx_reg + cx;
                    py_next    = ly_reg + cy;
                    state_next = sqfb_pkg::S_PT_DONE;
                end
            end

            // Use the point: a containment test or a stored corner.
            sqfb_pkg::S_PT_DONE:
            begin
                unique case (phase_reg)
                    sqfb_pkg::PH_DOWN:
                    begin
                        if (in_box)
                        begin
                            ang_next   = ang_reg - sqfb_pkg::DEG_ONE;
                            steps_next = steps_reg + 1'b1;
                            state_next = sqfb_pkg::S_WALK;
                        end
                        else
                        begin
                            ang_next   = ang_reg + sqfb_pkg::DEG_ONE;
                            phase_next = sqfb_pkg::PH_NR;
                            state_next = sqfb_pkg::S_EMIT;
                        end
                    end
                    sqfb_pkg::PH_NR:
                    begin
                        res_next.near_right_x = sqfb_pkg::to_q16_8(px_reg);
                        res_next.near_right_y = sqfb_pkg::to_q16_8(py_reg);
                        phase_next = sqfb_pkg::PH_FR;
                        state_next = sqfb_pkg::S_EMIT;
                    end
                    sqfb_pkg::PH_FR:
                    begin
                        res_next.far_right_x = sqfb_pkg::to_q16_8(px_reg);
                        res_next.far_right_y = sqfb_pkg::to_q16_8(py_reg);
                        steps_next = '0;
                        phase_next = sqfb_pkg::PH_UP;
                        state_next = sqfb_pkg::S_WALK;
                    end
                    sqfb_pkg::PH_UP:
                    begin
                        if (in_box)
                        begin
                            ang_next   = ang_reg + sqfb_pkg::DEG_ONE;
                            steps_next = steps_reg + 1'b1;
                            state_next = sqfb_pkg::S_WALK;
                        end
                        else
                        begin
                            ang_next   = ang_reg - sqfb_pkg::DEG_ONE;
                            phase_next = sqfb_pkg::PH_FL;
                            state_next = sqfb_pkg::S_EMIT;
                        end
                    end
                    sqfb_pkg::PH_FL:
                    begin
                        res_next.far_left_x = sqfb_pkg::to_q16_8(px_reg);
                        res_next.far_left_y = sqfb_pkg::to_q16_8(py_reg);
                        phase_next = sqfb_pkg::PH_NL;
                        state_next = sqfb_pkg::S_EMIT;
                    end
                    sqfb_pkg::PH_NL:
                    begin
                        res_next.near_left_x = sqfb_pkg::to_q16_8(px_reg);
                        res_next.near_left_y = sqfb_pkg::to_q16_8(py_reg);
                        res_next.gave_up     = gave_reg;
                        state_next           = sqfb_pkg::S_OUT;
                    end
                    default:
                        state_next = sqfb_pkg::S_IDLE;
                endcase
            end

            sqfb_pkg::S_OUT:
            begin
                if (quad.ready)
                    state_next = sqfb_pkg::S_IDLE;
            end

            default:
                state_next = sqfb_pkg::S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sqfb_pkg::S_IDLE;
            phase_reg <= sqfb_pkg::PH_DOWN;
            steps_reg <= '0;
            gave_reg  <= 1'b0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            steps_reg <= steps_next;
            gave_reg  <= gave_next;
            neg_reg   <= neg_next;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge clk)
    begin
        lx_reg  <= lx_next;
        ly_reg  <= ly_next;
        rad_reg <= rad_next;
        bl_reg  <= bl_next;
        bt_reg  <= bt_next;
        br_reg  <= br_next;
        bb_reg  <= bb_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        len_reg <= len_next;
        ang_reg <= ang_next;
        ptr_reg <= ptr_next;
        za_reg  <= za_next;
        x0_reg  <= x0_next;
        px_reg  <= px_next;
        py_reg  <= py_next;
        res_reg <= res_next;
    end

    assign job.ready  = (state_reg == sqfb_pkg::S_IDLE);
    assign quad.valid = (state_reg == sqfb_pkg::S_OUT);
    assign quad.data  = res_reg;

    `SQFB_ASSERT_NXT(a_accept_starts, clk, rst_n, job.valid && job.ready,
        state_reg == sqfb_pkg::S_VEC && !gave_reg)
    `SQFB_ASSERT_IMP(a_steps_capped, clk, rst_n, 1'b1, steps_reg <= STEP_CAP)
    `SQFB_ASSERT_IMP(a_cordic_idle_on_start, clk, rst_n,
        state_reg == sqfb_pkg::S_PT_ROT || state_reg == sqfb_pkg::S_VEC, !sts.busy)
    `SQFB_ASSERT_NXT(a_result_held, clk, rst_n, quad.valid && !quad.ready,
        quad.valid && $stable(res_reg))

endmodule

`default_nettype wire
